### src/mptg_pkg.sv
// Shared types and constants for the mirror-padded tile address generator.
`timescale 1ns / 1ps

package mptg_pkg;

    localparam int GRID_IDX_W  = 6;
    localparam int OFFSET_W    = 14;
    localparam int SRC_W       = 13;
    localparam int DIM_W       = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int IMG_SIZE_W  = 14;
    localparam int GRID_CNT_W  = 7;
    localparam int BORDER_W    = 10;

    localparam int RST_IMG_SIZE  = 512;
    localparam int RST_GRID_CNT  = 1;

    typedef logic [SRC_W-1:0]    src_t;
    typedef logic [DIM_W-1:0]    dim_t;
    typedef logic [BORDER_W-1:0] border_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS    = 3'd0,
        CFG_IMAGE_COLUMNS = 3'd1,
        CFG_TILES_DOWN    = 3'd2,
        CFG_TILES_ACROSS  = 3'd3,
        CFG_BORDER_BEFORE = 3'd4,
        CFG_BORDER_AFTER  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [GRID_IDX_W-1:0] grid_row;
        logic [GRID_IDX_W-1:0] grid_col;
        logic [OFFSET_W-1:0]   offset_row;
        logic [OFFSET_W-1:0]   offset_col;
    } in_item_t;

    typedef struct packed {
        src_t source_row;
        src_t source_col;
        dim_t tile_height;
        dim_t tile_width;
        logic in_range;
    } out_item_t;

    // sideband carried through the boundary dividers
    typedef struct packed {
        logic [OFFSET_W-1:0] offset_row;
        logic [OFFSET_W-1:0] offset_col;
        logic                bad_tile;
    } tag_a_t;

    // sideband carried through the mirror-modulo dividers
    typedef struct packed {
        dim_t tile_height;
        dim_t tile_width;
        logic in_range;
        logic bad_tile;
    } tag_b_t;

endpackage

### src/mirror_padded_tile_address_gen.sv
// Top level: padded tile bounds and mirrored source address per pixel request.
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  s_       | s_valid, s_ready, s_data (in_item_t)  | in
//  m_       | m_valid, m_ready, m_data (out_item_t) | out
//  cfg_     | cfg_valid, cfg_ready, cfg_index/data  | in
//
//  One beat per cycle sustained while the pipeline is not stalled. The depth is set by the
//  two restoring divider pipelines, one bit per stage: tile boundaries (COORD_BITS+8)
//  and mirror modulo (max(COORD_BITS, 11)+1). Synchronous active-low reset clears all
//  valid bits and loads the default config. The whole pipeline stalls only when the
//  output register and its skid entry are both full; s_ready is a register, and one
//  more beat is taken while a result waits.
`timescale 1ns / 1ps

module mirror_padded_tile_address_gen
    import mptg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int MAX_GRID   = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int S_W   = COORD_BITS + 1;              // image size, 1..2^COORD_BITS
    localparam int G_W   = $clog2(MAX_GRID + 1);        // grid count
    localparam int NA_W  = S_W + GRID_IDX_W + 1;        // size * (index + 1)
    localparam int HW    = ((COORD_BITS > 11) ? COORD_BITS : 11) + 1;  // padded extent
    localparam int PW    = HW + 1;                      // signed position
    localparam int NB_W  = HW;                          // folded position
    localparam int DB_W  = COORD_BITS + 2;              // twice the size

    logic [S_W-1:0] rows;
    logic [S_W-1:0] cols;
    logic [G_W-1:0] tiles_down;
    logic [G_W-1:0] tiles_across;
    border_t        border_before;
    border_t        border_after;

    logic pipe_en;

    mptg_cfg_regs #(
        .COORD_BITS (COORD_BITS),
        .MAX_GRID   (MAX_GRID)
    ) u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rows_o          (rows),
        .cols_o          (cols),
        .tiles_down_o    (tiles_down),
        .tiles_across_o  (tiles_across),
        .border_before_o (border_before),
        .border_after_o  (border_after)
    );

    assign cfg_ready = 1'b1;

    // ---------------- input stage ----------------
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     in_bad_reg;
    logic     in_bad_next;

    assign in_bad_next = (32'(s_data.grid_row) >= 32'(tiles_down)) ||
                         (32'(s_data.grid_col) >= 32'(tiles_across));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in_item_reg <= s_data;
            in_bad_reg  <= in_bad_next;
        end
    end

    // ---------------- boundary products ----------------
    logic                     mul_valid_reg;
    logic [3:0][NA_W-1:0]     mul_num_reg;
    logic [3:0][NA_W-1:0]     mul_num_next;
    tag_a_t                   mul_tag_reg;
    logic [3:0][G_W-1:0]      div_a_den;

    // lanes: row start, row end, column start, column end
    always_comb begin
        mul_num_next[0] = NA_W'(rows) * NA_W'(in_item_reg.grid_row);
        mul_num_next[1] = NA_W'(rows) * (NA_W'(in_item_reg.grid_row) + NA_W'(1));
        mul_num_next[2] = NA_W'(cols) * NA_W'(in_item_reg.grid_col);
        mul_num_next[3] = NA_W'(cols) * (NA_W'(in_item_reg.grid_col) + NA_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            mul_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mul_num_reg            <= mul_num_next;
            mul_tag_reg.offset_row <= in_item_reg.offset_row;
            mul_tag_reg.offset_col <= in_item_reg.offset_col;
            mul_tag_reg.bad_tile   <= in_bad_reg;
        end
    end

    assign div_a_den = {tiles_across, tiles_across, tiles_down, tiles_down};

    logic                 a_valid;
    logic [3:0][NA_W-1:0] a_quot;
    tag_a_t               a_tag;

    mptg_div_pipe #(
        .LANES (4),
        .NUM_W (NA_W),
        .DEN_W (G_W),
        .TAG_W ($bits(tag_a_t))
    ) u_div_bounds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (mul_valid_reg),
        .num_i     (mul_num_reg),
        .den_i     (div_a_den),
        .tag_i     (mul_tag_reg),
        .out_valid (a_valid),
        .quot_o    (a_quot),
        .rem_o     (),
        .tag_o     (a_tag)
    );

    // ---------------- extents, range check, reflect negatives ----------------
    function automatic logic [NB_W-1:0] fold_negative(input logic [PW-1:0] pos);
        logic [PW-1:0] folded;
        folded = pos[PW-1] ? ~pos : pos;   // -p - 1
        return folded[NB_W-1:0];
    endfunction

    logic [S_W-1:0]  row_start_q, row_end_q, col_start_q, col_end_q;
    logic [HW-1:0]   row_ext, col_ext;
    logic [PW-1:0]   row_pos, col_pos;
    logic            ext_ok;
    tag_b_t          ext_tag_next;

    always_comb begin
        row_start_q = S_W'(a_quot[0]);
        row_end_q   = S_W'(a_quot[1]);
        col_start_q = S_W'(a_quot[2]);
        col_end_q   = S_W'(a_quot[3]);
        row_ext = HW'(row_end_q) - HW'(row_start_q) + HW'(border_before) + HW'(border_after);
        col_ext = HW'(col_end_q) - HW'(col_start_q) + HW'(border_before) + HW'(border_after);
        row_pos = PW'(row_start_q) + PW'(a_tag.offset_row) - PW'(border_before);
        col_pos = PW'(col_start_q) + PW'(a_tag.offset_col) - PW'(border_before);
        ext_ok  = !a_tag.bad_tile &&
                  (32'(a_tag.offset_row) < 32'(row_ext)) &&
                  (32'(a_tag.offset_col) < 32'(col_ext));
        ext_tag_next.tile_height = dim_t'(row_ext);
        ext_tag_next.tile_width  = dim_t'(col_ext);
        ext_tag_next.in_range    = ext_ok;
        ext_tag_next.bad_tile    = a_tag.bad_tile;
    end

    logic                 ext_valid_reg;
    logic [1:0][NB_W-1:0] ext_pos_reg;
    tag_b_t               ext_tag_reg;
    logic [1:0][DB_W-1:0] div_b_den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            ext_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ext_pos_reg[0] <= fold_negative(row_pos);
            ext_pos_reg[1] <= fold_negative(col_pos);
            ext_tag_reg    <= ext_tag_next;
        end
    end

    assign div_b_den = {{cols, 1'b0}, {rows, 1'b0}};

    logic                 b_valid;
    logic [1:0][DB_W-1:0] b_rem;
    tag_b_t               b_tag;

    mptg_div_pipe #(
        .LANES (2),
        .NUM_W (NB_W),
        .DEN_W (DB_W),
        .TAG_W ($bits(tag_b_t))
    ) u_div_mirror (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (ext_valid_reg),
        .num_i     (ext_pos_reg),
        .den_i     (div_b_den),
        .tag_i     (ext_tag_reg),
        .out_valid (b_valid),
        .quot_o    (),
        .rem_o     (b_rem),
        .tag_o     (b_tag)
    );

    // ---------------- fold upper half, format result ----------------
    logic [DB_W-1:0] src_row_m, src_col_m;
    out_item_t       res;

    always_comb begin
        src_row_m = (b_rem[0] >= DB_W'(rows)) ?
                    DB_W'({rows, 1'b0}) - DB_W'(1) - b_rem[0] : b_rem[0];
        src_col_m = (b_rem[1] >= DB_W'(cols)) ?
                    DB_W'({cols, 1'b0}) - DB_W'(1) - b_rem[1] : b_rem[1];
        res = '0;
        if (!b_tag.bad_tile) begin
            res.tile_height = b_tag.tile_height;
            res.tile_width  = b_tag.tile_width;
            res.in_range    = b_tag.in_range;
            if (b_tag.in_range) begin
                res.source_row = src_row_m[SRC_W-1:0] & src_t'(src_row_m);
                res.source_col = src_col_m[SRC_W-1:0] & src_t'(src_col_m);
            end
        end
    end

    // ---------------- output register with skid entry ----------------
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= b_valid;
            end
        end else if (pipe_en && b_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : res;
        end else if (pipe_en && b_valid) begin
            skid_item_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

`ifndef SYNTHESIS
    // the skid entry fills only behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output valid");

    // a result that misses the tile carries no source coordinate
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.in_range) |-> (m_data.source_row == '0 && m_data.source_col == '0))
        else $error("out-of-range result with nonzero source");

    // a stalled output with a full skid keeps the input closed on the next edge
    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_valid && !m_ready) |=> !s_ready)
        else $error("input opened while output stalled and skid full");
`endif

endmodule

### src/mptg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
`timescale 1ns / 1ps

module mptg_div_pipe
    import mptg_pkg::*;
#(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]    num_i,
    input  logic [LANES-1:0][DEN_W-1:0]    den_i,
    input  logic [TAG_W-1:0]               tag_i,
    output logic                           out_valid,
    output logic [LANES-1:0][NUM_W-1:0]    quot_o,
    output logic [LANES-1:0][DEN_W-1:0]    rem_o,
    output logic [TAG_W-1:0]               tag_o
);

    logic                           v_reg    [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]    nq_reg   [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]    nq_next  [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]    rem_reg  [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]    rem_next [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]    den_reg  [NUM_W];
    logic [TAG_W-1:0]               tag_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic                        v_src;
        logic [LANES-1:0][NUM_W-1:0] nq_src;
        logic [LANES-1:0][DEN_W-1:0] rem_src;
        logic [LANES-1:0][DEN_W-1:0] den_src;
        logic [TAG_W-1:0]            tag_src;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign nq_src  = num_i;
            assign rem_src = '0;
            assign den_src = den_i;
            assign tag_src = tag_i;
        end else begin : g_rest
            assign v_src   = v_reg[k-1];
            assign nq_src  = nq_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign den_src = den_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        // nq holds the numerator bits still to shift in, quotient bits enter at the bottom
        always_comb begin : p_step
            logic [DEN_W:0] trial;
            for (int l = 0; l < LANES; l++) begin
                trial = {rem_src[l], nq_src[l][NUM_W-1]};
                if (trial >= {1'b0, den_src[l]}) begin
                    rem_next[k][l] = DEN_W'(trial - {1'b0, den_src[l]});
                    nq_next[k][l]  = {nq_src[l][NUM_W-2:0], 1'b1};
                end else begin
                    rem_next[k][l] = trial[DEN_W-1:0];
                    nq_next[k][l]  = {nq_src[l][NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]  <= nq_next[k];
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_src;
                tag_reg[k] <= tag_src;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quot_o    = nq_reg[NUM_W-1];
    assign rem_o     = rem_reg[NUM_W-1];
    assign tag_o     = tag_reg[NUM_W-1];

endmodule

### src/mptg_cfg_regs.sv
// Configuration registers, stored already saturated to their usable ranges.
`timescale 1ns / 1ps

module mptg_cfg_regs
    import mptg_pkg::*;
#(
    parameter int COORD_BITS = 13,
    parameter int MAX_GRID   = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic [COORD_BITS:0]          rows_o,
    output logic [COORD_BITS:0]          cols_o,
    output logic [$clog2(MAX_GRID+1)-1:0] tiles_down_o,
    output logic [$clog2(MAX_GRID+1)-1:0] tiles_across_o,
    output border_t                      border_before_o,
    output border_t                      border_after_o
);

    localparam int S_W      = COORD_BITS + 1;
    localparam int G_W      = $clog2(MAX_GRID + 1);
    localparam int MAX_SIZE = 1 << COORD_BITS;
    localparam int RST_SIZE = (RST_IMG_SIZE > MAX_SIZE) ? MAX_SIZE : RST_IMG_SIZE;

    logic [S_W-1:0] rows_reg;
    logic [S_W-1:0] cols_reg;
    logic [G_W-1:0] td_reg;
    logic [G_W-1:0] ta_reg;
    border_t        pb_reg;
    border_t        pa_reg;

    logic [IMG_SIZE_W-1:0] size_raw;
    logic [GRID_CNT_W-1:0] grid_raw;
    logic [S_W-1:0]        size_sat;
    logic [G_W-1:0]        grid_sat;

    // zero acts as one, large values saturate
    always_comb begin
        size_raw = cfg_data[IMG_SIZE_W-1:0];
        grid_raw = cfg_data[GRID_CNT_W-1:0];
        if (size_raw == '0) begin
            size_sat = S_W'(1);
        end else if (32'(size_raw) > 32'(MAX_SIZE)) begin
            size_sat = S_W'(MAX_SIZE);
        end else begin
            size_sat = S_W'(size_raw);
        end
        if (grid_raw == '0) begin
            grid_sat = G_W'(1);
        end else if (32'(grid_raw) > 32'(MAX_GRID)) begin
            grid_sat = G_W'(MAX_GRID);
        end else begin
            grid_sat = G_W'(grid_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= S_W'(RST_SIZE);
            cols_reg <= S_W'(RST_SIZE);
            td_reg   <= G_W'(RST_GRID_CNT);
            ta_reg   <= G_W'(RST_GRID_CNT);
            pb_reg   <= '0;
            pa_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_ROWS:    rows_reg <= size_sat;
                CFG_IMAGE_COLUMNS: cols_reg <= size_sat;
                CFG_TILES_DOWN:    td_reg   <= grid_sat;
                CFG_TILES_ACROSS:  ta_reg   <= grid_sat;
                CFG_BORDER_BEFORE: pb_reg   <= cfg_data[BORDER_W-1:0];
                CFG_BORDER_AFTER:  pa_reg   <= cfg_data[BORDER_W-1:0];
                default: ;
            endcase
        end
    end

    assign rows_o          = rows_reg;
    assign cols_o          = cols_reg;
    assign tiles_down_o    = td_reg;
    assign tiles_across_o  = ta_reg;
    assign border_before_o = pb_reg;
    assign border_after_o  = pa_reg;

endmodule

### sim/mirror_padded_tile_address_gen_tb.sv
// Self-checking testbench for mirror_padded_tile_address_gen: corners, random, backpressure.
`timescale 1ns / 1ps

module mirror_padded_tile_address_gen_tb;
    import mptg_pkg::*;

    localparam int COORD_BITS   = 13;
    localparam int MAX_GRID     = 64;
    localparam int LATENCY      = 2 * COORD_BITS + 13;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // indexes past the last register, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow copy of the register file
    logic [IMG_SIZE_W-1:0] cfg_rows = IMG_SIZE_W'(RST_IMG_SIZE);
    logic [IMG_SIZE_W-1:0] cfg_cols = IMG_SIZE_W'(RST_IMG_SIZE);
    logic [GRID_CNT_W-1:0] cfg_td   = GRID_CNT_W'(RST_GRID_CNT);
    logic [GRID_CNT_W-1:0] cfg_ta   = GRID_CNT_W'(RST_GRID_CNT);
    logic [BORDER_W-1:0]   cfg_pb   = '0;
    logic [BORDER_W-1:0]   cfg_pa   = '0;

    out_item_t pending_addr[$];
    out_item_t want_addr;

    int  err_count       = 0;
    int  n_sent          = 0;
    int  n_checked       = 0;
    int  n_cfg_writes    = 0;
    int  input_stalls    = 0;
    int  hold_off_cycles = 0;
    bit  tx_idle_en      = 1'b1;
    bit  rx_idle_en      = 1'b1;

    mirror_padded_tile_address_gen #(
        .COORD_BITS(COORD_BITS),
        .MAX_GRID  (MAX_GRID)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d beats sent, %0d results checked", n_sent, n_checked);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int clamp_range(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void effective_geometry(output int rows, output int cols,
                                               output int td, output int ta);
        rows = clamp_range(int'(cfg_rows), 1, 1 << COORD_BITS);
        cols = clamp_range(int'(cfg_cols), 1, 1 << COORD_BITS);
        td   = clamp_range(int'(cfg_td), 1, MAX_GRID);
        ta   = clamp_range(int'(cfg_ta), 1, MAX_GRID);
    endfunction

    function automatic void tile_span(input int size, input int count, input int idx,
                                      output int start_pos, output int extent);
        int stop_pos;
        start_pos = size * idx / count - int'(cfg_pb);
        stop_pos  = size * (idx + 1) / count + int'(cfg_pa);
        extent    = stop_pos - start_pos;
    endfunction

    // half-sample symmetric reflection into [0, size)
    function automatic int reflect_coord(input int pos, input int size);
        int p;
        p = pos;
        if (p < 0) p = -p - 1;
        if (p >= 2 * size) p = p % (2 * size);
        if (p >= size) p = 2 * size - 1 - p;
        return p;
    endfunction

    function automatic out_item_t source_address(input in_item_t px);
        out_item_t addr;
        int rows, cols, td, ta, r0, h, c0, w, orow, ocol, sr, sc;
        addr = '0;
        effective_geometry(rows, cols, td, ta);
        if (px.grid_row >= td || px.grid_col >= ta) return addr;
        tile_span(rows, td, int'(px.grid_row), r0, h);
        tile_span(cols, ta, int'(px.grid_col), c0, w);
        addr.tile_height = h[DIM_W-1:0];
        addr.tile_width  = w[DIM_W-1:0];
        orow = int'(px.offset_row);
        ocol = int'(px.offset_col);
        if (orow < h && ocol < w) begin
            sr = reflect_coord(r0 + orow, rows);
            sc = reflect_coord(c0 + ocol, cols);
            addr.source_row = sr[SRC_W-1:0];
            addr.source_col = sc[SRC_W-1:0];
            addr.in_range   = 1'b1;
        end
        return addr;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // mostly back-to-back, sometimes a short gap, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic in_item_t pixel(input int gr, input int gc, input int orow, input int ocol);
        in_item_t px;
        px.grid_row   = gr[GRID_IDX_W-1:0];
        px.grid_col   = gc[GRID_IDX_W-1:0];
        px.offset_row = orow[OFFSET_W-1:0];
        px.offset_col = ocol[OFFSET_W-1:0];
        return px;
    endfunction

    function automatic int offset_within(input int extent);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return extent;
        if (extent == 0) return 0;
        if (r == 1) return extent - 1;
        return $urandom_range(0, extent - 1);
    endfunction

    // mostly requests in a real tile (an offset may sit one past its end), the rest raw noise
    function automatic in_item_t random_pixel();
        in_item_t px;
        int rows, cols, td, ta, r0, h, c0, w;
        px = in_item_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 80) begin
            effective_geometry(rows, cols, td, ta);
            px.grid_row = GRID_IDX_W'($urandom_range(0, td - 1));
            px.grid_col = GRID_IDX_W'($urandom_range(0, ta - 1));
            tile_span(rows, td, int'(px.grid_row), r0, h);
            tile_span(cols, ta, int'(px.grid_col), c0, w);
            px.offset_row = OFFSET_W'(offset_within(h));
            px.offset_col = OFFSET_W'(offset_within(w));
        end
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return 14'd0;
            1:       return 14'd1;
            2:       return 14'd8192;
            3:       return 14'h3FFF;
            4, 5, 6: return CFG_DATA_W'($urandom_range(1, 64));
            default: return CFG_DATA_W'($urandom_range(1, 8192));
        endcase
    endfunction

    // unused upper data bits carry junk
    function automatic logic [CFG_DATA_W-1:0] random_count();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v[GRID_CNT_W-1:0] = 7'd0;
            1:       v[GRID_CNT_W-1:0] = 7'd1;
            2:       v[GRID_CNT_W-1:0] = 7'd64;
            3:       v[GRID_CNT_W-1:0] = GRID_CNT_W'($urandom_range(65, 127));
            default: v[GRID_CNT_W-1:0] = GRID_CNT_W'($urandom_range(1, 64));
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_border();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v[BORDER_W-1:0] = 10'd0;
            1:       v[BORDER_W-1:0] = 10'd1023;
            2, 3, 4: v[BORDER_W-1:0] = BORDER_W'($urandom_range(0, 8));
            default: v[BORDER_W-1:0] = BORDER_W'($urandom_range(0, 1023));
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------- channel tasks

    task automatic send_pixel(input in_item_t px);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = px;
        do @(posedge aclk); while (!s_ready);
        pending_addr.insert(pending_addr.size(), source_address(px));
        n_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_IMAGE_ROWS:    cfg_rows = value[IMG_SIZE_W-1:0];
            CFG_IMAGE_COLUMNS: cfg_cols = value[IMG_SIZE_W-1:0];
            CFG_TILES_DOWN:    cfg_td   = value[GRID_CNT_W-1:0];
            CFG_TILES_ACROSS:  cfg_ta   = value[GRID_CNT_W-1:0];
            CFG_BORDER_BEFORE: cfg_pb   = value[BORDER_W-1:0];
            CFG_BORDER_AFTER:  cfg_pa   = value[BORDER_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_geometry(input logic [CFG_DATA_W-1:0] rows,
                                  input logic [CFG_DATA_W-1:0] cols,
                                  input logic [CFG_DATA_W-1:0] td,
                                  input logic [CFG_DATA_W-1:0] ta,
                                  input logic [CFG_DATA_W-1:0] pb,
                                  input logic [CFG_DATA_W-1:0] pa);
        cfg_write(CFG_IMAGE_ROWS, rows);
        cfg_write(CFG_IMAGE_COLUMNS, cols);
        cfg_write(CFG_TILES_DOWN, td);
        cfg_write(CFG_TILES_ACROSS, ta);
        cfg_write(CFG_BORDER_BEFORE, pb);
        cfg_write(CFG_BORDER_AFTER, pa);
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle_pipeline();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_addr.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- result side

    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
                m_ready    = 1'b0;
                stall_left = pick_gap();
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0d expected %0d (result %0d)", name, got, want, n_checked));
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            if (pending_addr.size() == 0) begin
                flag_error($sformatf("result beat with nothing outstanding: %h", m_data));
            end else begin
                want_addr = pending_addr.pop_front();
                compare_field("source_row", 32'(m_data.source_row), 32'(want_addr.source_row));
                compare_field("source_col", 32'(m_data.source_col), 32'(want_addr.source_col));
                compare_field("tile_height", 32'(m_data.tile_height),
                              32'(want_addr.tile_height));
                compare_field("tile_width", 32'(m_data.tile_width), 32'(want_addr.tile_width));
                compare_field("in_range", 32'(m_data.in_range), 32'(want_addr.in_range));
                n_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // 512x512 single tile, no border
    task automatic test_reset_defaults();
        send_pixel(pixel(0, 0, 0, 0));
        send_pixel(pixel(0, 0, 511, 511));
        send_pixel(pixel(0, 0, 512, 0));
        send_pixel(pixel(1, 0, 0, 0));
        send_pixel(pixel(0, 63, 16383, 16383));
    endtask

    // zero sizes act as 1, oversize values saturate
    task automatic test_size_saturation();
        settle_pipeline();
        apply_geometry(14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
        send_pixel(pixel(0, 0, 0, 0));
        send_pixel(pixel(0, 0, 1, 0));
        settle_pipeline();
        apply_geometry(14'h3FFF, 14'd8192, 14'd127, 14'd64, 14'd1023, 14'd1023);
        send_pixel(pixel(0, 0, 0, 0));
        send_pixel(pixel(63, 63, 2173, 2173));
        send_pixel(pixel(63, 63, 16383, 16383));
    endtask

    // tiny image, huge border: positions below zero and past twice the size
    task automatic test_mirror_folding();
        settle_pipeline();
        apply_geometry(14'd3, 14'd5, 14'd1, 14'd1, 14'd1023, 14'd1023);
        send_pixel(pixel(0, 0, 0, 0));
        send_pixel(pixel(0, 0, 1023, 1023));
        send_pixel(pixel(0, 0, 2048, 2050));
        send_pixel(pixel(0, 0, 2049, 0));
    endtask

    // more tiles than pixels: some tiles have zero extent
    task automatic test_empty_tiles();
        settle_pipeline();
        apply_geometry(14'd2, 14'd3, 14'd5, 14'd4, 14'd0, 14'd0);
        send_pixel(pixel(0, 0, 0, 0));
        send_pixel(pixel(4, 3, 0, 0));
        send_pixel(pixel(5, 0, 0, 0));
    endtask

    task automatic test_unknown_register();
        settle_pipeline();
        cfg_write(CFG_SPARE_6, 14'h3FFF);
        cfg_write(CFG_SPARE_7, 14'h0001);
        send_pixel(pixel(4, 3, 0, 0));
        send_pixel(pixel(1, 1, 0, 0));
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            settle_pipeline();
            if (ph == 0) begin
                apply_geometry(14'h3FFF, 14'h3FFF, 14'd127, 14'd127, 14'd1023, 14'd1023);
            end else if (ph == 1) begin
                apply_geometry(14'd1, 14'd1, 14'd64, 14'd64, 14'd0, 14'd0);
            end else begin
                apply_geometry(random_size(), random_size(), random_count(), random_count(),
                               random_border(), random_border());
                if ($urandom_range(0, 3) == 0)
                    cfg_write($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                              CFG_DATA_W'($urandom));
            end
            // some phases run with one side never idling
            tx_idle_en = (ph % 4) != 1;
            rx_idle_en = (ph % 4) != 2;
            repeat (per_phase) send_pixel(random_pixel());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // result side frozen long enough for the pipeline to fill and stop taking beats
    task automatic test_output_backpressure();
        settle_pipeline();
        apply_geometry(14'd200, 14'd300, 14'd4, 14'd3, 14'd5, 14'd7);
        tx_idle_en      = 1'b0;
        hold_off_cycles = 300;
        repeat (60) send_pixel(random_pixel());
        tx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_size_saturation();
        test_mirror_folding();
        test_empty_tiles();
        test_unknown_register();
        test_random_traffic(13, 146);
        test_output_backpressure();

        settle_pipeline();
        repeat (LATENCY + 10) @(posedge aclk);

        $display("Sent %0d pixel requests, checked %0d addresses, %0d register writes.",
                 n_sent, n_checked, n_cfg_writes);
        $display("Input channel was held off for %0d cycles; %0d mismatches.",
                 input_stalls, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### mirror_padded_tile_address_gen.f
src/mptg_pkg.sv
src/mptg_div_pipe.sv
src/mptg_cfg_regs.sv
src/mirror_padded_tile_address_gen.sv
sim/mirror_padded_tile_address_gen_tb.sv
